/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, sampled on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/pgpc_pkg.sv */
// ----------------------------------------------------------------------------
// pgpc_pkg
// constants, command and status types and the pair row function of the
// genotype pair counter
// ----------------------------------------------------------------------------
package pgpc_pkg;

  localparam int MAX_ROWS       = 32;
  localparam int COUNT_BITS     = 16;
  localparam int ROW_BITS       = $clog2(MAX_ROWS);
  localparam int NUM_PAIRS      = (MAX_ROWS * (MAX_ROWS - 1)) / 2;
  localparam int PAIR_ADDR_BITS = $clog2(NUM_PAIRS);
  localparam int CODES          = 3;
  localparam int NUM_LANES      = CODES * CODES;
  localparam int LANE_BITS      = $clog2(NUM_LANES);
  localparam int ROW_WIDTH      = NUM_LANES * COUNT_BITS;
  localparam int OUT_BITS       = 16;
  localparam int OUT_DATA_BITS  = NUM_LANES * OUT_BITS;
  localparam int CFG_BITS       = 6;
  localparam int GENO_BITS      = 2;
  localparam int REQ_BITS       = 2;
  localparam int IN_DATA_BITS   = 16;

  localparam logic [GENO_BITS-1:0] GENO_MISSING = 2'd3;

  localparam logic [REQ_BITS-1:0] REQ_CODE  = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic load_code;
    logic load_pair;
    logic scan_en;
    logic clr_en;
    logic rd_issue;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic scan_last;
    logic clr_last;
    logic out_free;
    logic pipe_busy;
  } dp_status_t;

  // row of the count memory for pair (lo, hi): hi*(hi-1)/2 + lo
  function automatic logic [PAIR_ADDR_BITS-1:0] pair_row(
    input logic [ROW_BITS-1:0] lo,
    input logic [ROW_BITS-1:0] hi
  );
    logic [2*ROW_BITS-1:0] prod;
    prod = (2*ROW_BITS)'(hi) * (2*ROW_BITS)'(hi - 1'b1);
    return PAIR_ADDR_BITS'((prod >> 1) + (2*ROW_BITS)'(lo));
  endfunction

endpackage

/* rtl/pgpc_ram.sv */
// ----------------------------------------------------------------------------
// pgpc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pgpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/pgpc_ctrl.sv */
// ----------------------------------------------------------------------------
// pgpc_ctrl
// sequencer of the pair counter: clearing sweep, row scan, pair read
// ----------------------------------------------------------------------------
module pgpc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pgpc_pkg::REQ_BITS-1:0]  req_type,
  output pgpc_pkg::dp_cmd_t              cmd,
  input  pgpc_pkg::dp_status_t           status
);
  import pgpc_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_DRAIN    = 3'd3;
  localparam logic [2:0] ST_RD_ISSUE = 3'd4;
  localparam logic [2:0] ST_RD_LOAD  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          case (req_type)
            REQ_CODE: begin
              cmd.load_code = 1'b1;
              if (status.scan_needed) begin
                state_next = ST_SCAN;
              end
            end
            REQ_READ: begin
              cmd.load_pair = 1'b1;
              state_next    = ST_RD_ISSUE;
            end
            REQ_CLEAR: begin
              state_next = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last read-modify-write retires here
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_LOAD;
      end
      ST_RD_LOAD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/pgpc_datapath.sv */
// ----------------------------------------------------------------------------
// pgpc_datapath
// column code store, row position, count memory with its read-modify-write
// pipe, clearing counter and output register
// ----------------------------------------------------------------------------
module pgpc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  pgpc_pkg::dp_cmd_t                   cmd,
  output pgpc_pkg::dp_status_t                status,
  input  logic                                cfg_wen,
  input  logic [pgpc_pkg::CFG_BITS-1:0]       cfg_wdata,
  input  logic [pgpc_pkg::GENO_BITS-1:0]      genotype,
  input  logic [pgpc_pkg::ROW_BITS-1:0]       pair_first,
  input  logic [pgpc_pkg::ROW_BITS-1:0]       pair_second,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pgpc_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  output logic                                m_tuser
);
  import pgpc_pkg::*;

  logic [CFG_BITS-1:0]       num_rows;
  logic [CFG_BITS-1:0]       rows_eff;
  logic [ROW_BITS-1:0]       row_pos;
  logic [ROW_BITS-1:0]       r_eff;
  logic [CFG_BITS-1:0]       r_inc;
  logic [GENO_BITS-1:0]      codes [MAX_ROWS];
  logic [ROW_BITS-1:0]       cur_r;
  logic [GENO_BITS-1:0]      cur_code;
  logic [ROW_BITS-1:0]       scan_s;
  logic [GENO_BITS-1:0]      scan_code;
  logic [PAIR_ADDR_BITS-1:0] scan_addr;
  logic                      pipe_v;
  logic [PAIR_ADDR_BITS-1:0] pipe_addr;
  logic [LANE_BITS-1:0]      pipe_lane;
  logic [ROW_BITS-1:0]       lo_q;
  logic [ROW_BITS-1:0]       hi_q;
  logic                      pair_ok;
  logic [PAIR_ADDR_BITS-1:0] clr_cnt;
  logic                      ram_wr_en;
  logic [PAIR_ADDR_BITS-1:0] ram_wr_addr;
  logic [ROW_WIDTH-1:0]      ram_wr_data;
  logic                      ram_rd_en;
  logic [PAIR_ADDR_BITS-1:0] ram_rd_addr;
  logic [ROW_WIDTH-1:0]      ram_rd_data;
  logic [ROW_WIDTH-1:0]      inc_row;
  logic [OUT_DATA_BITS-1:0]  out_row;

  // row count clamped to 2..MAX_ROWS
  always_comb begin
    if (num_rows < CFG_BITS'(2)) begin
      rows_eff = CFG_BITS'(2);
    end else if (num_rows > CFG_BITS'(MAX_ROWS)) begin
      rows_eff = CFG_BITS'(MAX_ROWS);
    end else begin
      rows_eff = num_rows;
    end
  end

  assign r_eff = (CFG_BITS'(row_pos) >= rows_eff) ? '0 : row_pos;
  assign r_inc = CFG_BITS'(r_eff) + CFG_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= CFG_BITS'(MAX_ROWS);
      row_pos  <= '0;
    end else if (cfg_wen) begin
      num_rows <= cfg_wdata;
      row_pos  <= '0;
    end else if (cmd.clr_en) begin
      row_pos <= '0;
    end else if (cmd.load_code) begin
      row_pos <= (r_inc >= rows_eff) ? '0 : r_inc[ROW_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_code) begin
      codes[r_eff] <= genotype;
      cur_r        <= r_eff;
      cur_code     <= genotype;
    end
    if (cmd.load_pair) begin
      lo_q <= pair_first;
      hi_q <= pair_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_s <= '0;
    end else if (cmd.load_code) begin
      scan_s <= '0;
    end else if (cmd.scan_en) begin
      scan_s <= scan_s + 1'b1;
    end
  end

  assign scan_code = codes[scan_s];
  assign scan_addr = pair_row(scan_s, cur_r);

  // read issued for earlier row s, increment written back in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= 1'b0;
    end else begin
      pipe_v <= cmd.scan_en && (scan_code != GENO_MISSING);
    end
  end

  always_ff @(posedge clk) begin
    pipe_addr <= scan_addr;
    pipe_lane <= LANE_BITS'(scan_code) * LANE_BITS'(CODES) + LANE_BITS'(cur_code);
  end

  always_comb begin
    logic [COUNT_BITS-1:0] lane_val;
    inc_row = ram_rd_data;
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_val = ram_rd_data[k*COUNT_BITS +: COUNT_BITS];
      if ((pipe_lane == LANE_BITS'(k)) && (lane_val != '1)) begin
        inc_row[k*COUNT_BITS +: COUNT_BITS] = lane_val + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= status.clr_last ? '0 : clr_cnt + 1'b1;
    end
  end

  assign pair_ok = (lo_q < hi_q) && (CFG_BITS'(hi_q) < rows_eff);

  assign ram_wr_en   = cmd.clr_en || pipe_v;
  assign ram_wr_addr = cmd.clr_en ? clr_cnt : pipe_addr;
  assign ram_wr_data = cmd.clr_en ? '0 : inc_row;
  assign ram_rd_en   = cmd.scan_en || cmd.rd_issue;
  assign ram_rd_addr = cmd.scan_en ? scan_addr :
                       (pair_ok ? pair_row(lo_q, hi_q) : '0);

  pgpc_ram #(
    .WIDTH (ROW_WIDTH),
    .DEPTH (NUM_PAIRS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // reported counts keep their low 16 bits
  always_comb begin
    logic [31:0] ext;
    for (int k = 0; k < NUM_LANES; k++) begin
      ext = 32'(ram_rd_data[k*COUNT_BITS +: COUNT_BITS]);
      out_row[k*OUT_BITS +: OUT_BITS] = pair_ok ? ext[OUT_BITS-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= out_row;
      m_tuser <= pair_ok;
    end
  end

  assign status.scan_needed = (genotype != GENO_MISSING) && (r_eff != '0);
  assign status.scan_last   = (scan_s == cur_r - 1'b1);
  assign status.clr_last    = (clr_cnt == PAIR_ADDR_BITS'(NUM_PAIRS - 1));
  assign status.out_free    = !m_tvalid || m_tready;
  assign status.pipe_busy   = pipe_v;

endmodule

/* rtl/pairwise_genotype_pair_counter.sv */
// ----------------------------------------------------------------------------
// pairwise_genotype_pair_counter
// counts 3x3 joint genotype tables for every row pair over streamed columns
//
//   channel   dir  contents
//   s_*       in   tuser req_type; tdata genotype, pair_first, pair_second
//   m_*       out  tdata count_00 .. count_22; tuser pair_ok
//   cfg_*     in   num_rows write
//
// a code item for row r > 0 whose code is not missing runs a scan of the
// earlier rows (one count-memory read-modify-write per earlier row, pipelined
// one a cycle through the single write port) and then a drain state; otherwise
// only the code is stored; a read item passes the read-issue and read-load
// states to the output register, waiting while a previous result still waits there
// after reset and after a clear item the count memory is swept, one pair row
// a cycle over all 496 pair rows, with s_tready low
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pairwise_genotype_pair_counter (
  input  logic                                clk,
  input  logic                                rst,
  // genotype [1:0], pair_first [6:2], pair_second [11:7], zero [15:12]
  input  logic [pgpc_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // req_type [1:0]
  input  logic [pgpc_pkg::REQ_BITS-1:0]       s_tuser,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // count_00 [15:0], count_01 [31:16], count_02, count_10, count_11,
  // count_12, count_20, count_21, count_22 [143:128]
  output logic [pgpc_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // pair_ok [0]
  output logic                                m_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_wen,
  input  logic [pgpc_pkg::CFG_BITS-1:0]       cfg_wdata
);
  import pgpc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [GENO_BITS-1:0] genotype;
  logic [ROW_BITS-1:0]  pair_first;
  logic [ROW_BITS-1:0]  pair_second;

  assign genotype    = s_tdata[GENO_BITS-1:0];
  assign pair_first  = s_tdata[GENO_BITS +: ROW_BITS];
  assign pair_second = s_tdata[GENO_BITS+ROW_BITS +: ROW_BITS];

  pgpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser),
    .cmd      (cmd),
    .status   (status)
  );

  pgpc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .genotype    (genotype),
    .pair_first  (pair_first),
    .pair_second (pair_second),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  // clearing sweep starts right out of reset
  `ASSERT_IMPLIES(a_clear_after_reset, $fell(rst), cmd.clr_en, "no clearing sweep after reset")
  // no item taken while a count write is still in flight
  `ASSERT_IMPLIES(a_ready_pipe_empty, s_tready, !status.pipe_busy, "ready with write pending")
  // a result never overwrites one still waiting
  `ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "result overwritten")

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives code, read, clear and ignored items into the genotype pair counter
// under random stalls on both sides, keeps its own copy of the 3x3 joint
// tables and checks every read result field by field, in order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pgpc_pkg::*;

  localparam logic [REQ_BITS-1:0] REQ_NONE = 2'd3;
  // longest quiet time of the block: a full clearing sweep plus margin
  localparam int SETTLE_CYCLES = 520;
  localparam int STEADY_COLUMNS = 40;

  typedef struct packed {
    logic                                ok;
    logic [NUM_LANES-1:0][OUT_BITS-1:0]  counts;
  } pair_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic [IN_DATA_BITS-1:0]   s_tdata = '0;
  logic [REQ_BITS-1:0]       s_tuser = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [OUT_DATA_BITS-1:0]  m_tdata;
  logic                      m_tuser;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic                      cfg_wen = 1'b0;
  logic [CFG_BITS-1:0]       cfg_wdata = '0;

  // shadow of the block state
  logic [CFG_BITS-1:0]   rows_q = 6'd32;
  logic [GENO_BITS-1:0]  col_codes [MAX_ROWS];
  int                    row_pos = 0;
  logic [COUNT_BITS-1:0] pair_tally [NUM_PAIRS][NUM_LANES];
  pair_result_t          pending_counts [$];

  bit steady = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int columns_done = 0;
  int row_settings = 0;

  pairwise_genotype_pair_counter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int eff_rows();
    if (rows_q < 2) return 2;
    if (rows_q > MAX_ROWS) return MAX_ROWS;
    return int'(rows_q);
  endfunction

  function automatic void tally_clear();
    foreach (pair_tally[p, k]) pair_tally[p][k] = '0;
    row_pos = 0;
  endfunction

  function automatic void tally_code(logic [GENO_BITS-1:0] code);
    int rows;
    int r;
    int pidx;
    int lane;
    rows = eff_rows();
    r = row_pos;
    if (r >= rows) r = 0;
    col_codes[r] = code;
    if (code != GENO_MISSING) begin
      for (int s = 0; s < r; s++) begin
        if (col_codes[s] != GENO_MISSING) begin
          pidx = (r * (r - 1)) / 2 + s;
          lane = int'(col_codes[s]) * CODES + int'(code);
          if (pair_tally[pidx][lane] != '1) pair_tally[pidx][lane]++;
        end
      end
    end
    r++;
    if (r >= rows) begin
      r = 0;
      columns_done++;
    end
    row_pos = r;
  endfunction

  function automatic void tally_read(logic [ROW_BITS-1:0] lo, logic [ROW_BITS-1:0] hi);
    pair_result_t want;
    int pidx;
    want = '0;
    if (lo < hi && int'(hi) < eff_rows()) begin
      want.ok = 1'b1;
      pidx = (int'(hi) * (int'(hi) - 1)) / 2 + int'(lo);
      for (int k = 0; k < NUM_LANES; k++) want.counts[k] = pair_tally[pidx][k][OUT_BITS-1:0];
    end
    pending_counts.push_back(want);
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
  endfunction

  function automatic void check_result();
    pair_result_t want;
    pair_result_t got;
    got.counts = m_tdata;
    got.ok = m_tuser;
    results_seen++;
    if (pending_counts.size() == 0) begin
      errors++;
      if (errors <= 10) $display("%0t: result with nothing outstanding", $realtime);
      return;
    end
    want = pending_counts.pop_front();
    for (int k = 0; k < NUM_LANES; k++)
      if (got.counts[k] !== want.counts[k])
        note_mismatch($sformatf("count_%0d%0d", k / CODES, k % CODES),
                      int'(want.counts[k]), int'(got.counts[k]));
    if (got.ok !== want.ok) note_mismatch("pair_ok", int'(want.ok), int'(got.ok));
  endfunction

  // receive side: random stalls, check each accepted item
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 20);
      if (m_tvalid && m_tready) check_result();
    end
  end

  task automatic send_item(input logic [REQ_BITS-1:0] req, input logic [GENO_BITS-1:0] geno,
                           input logic [ROW_BITS-1:0] lo, input logic [ROW_BITS-1:0] hi);
    while (!steady && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {4'd0, hi, lo, geno};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (req)
      REQ_CODE:  tally_code(geno);
      REQ_READ:  tally_read(lo, hi);
      REQ_CLEAR: tally_clear();
      default: ;
    endcase
    if (req != REQ_NONE) items_sent++;
  endtask

  task automatic send_code(input logic [GENO_BITS-1:0] geno);
    send_item(REQ_CODE, geno, ROW_BITS'($urandom_range(0, 31)), ROW_BITS'($urandom_range(0, 31)));
  endtask

  task automatic send_read(input int lo, input int hi);
    send_item(REQ_READ, GENO_BITS'($urandom_range(0, 3)), ROW_BITS'(lo), ROW_BITS'(hi));
  endtask

  task automatic send_clear();
    send_item(REQ_CLEAR, GENO_BITS'($urandom_range(0, 3)),
              ROW_BITS'($urandom_range(0, 31)), ROW_BITS'($urandom_range(0, 31)));
  endtask

  // hold the sender until every result is back and the block has gone quiet
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rows(input logic [CFG_BITS-1:0] value);
    quiesce();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    rows_q = value;
    row_pos = 0;
    row_settings++;
  endtask

  task automatic test_empty_reads();
    send_read(0, 1);
    send_read(30, 31);
    send_read(0, 31);
    send_read(5, 5);
    send_read(7, 3);
    // ignored request type in the middle of reads
    send_item(REQ_NONE, 2'd3, 5'd31, 5'd31);
  endtask

  task automatic test_joint_table();
    set_rows(6'd3);
    send_code(2'd0); send_code(2'd1); send_code(2'd2);
    send_code(2'd2); send_code(2'd0); send_code(2'd1);
    send_code(2'd1); send_code(2'd2); send_code(2'd0);
    // missing codes skip their pairs
    send_code(GENO_MISSING); send_code(2'd1); send_code(GENO_MISSING);
    send_read(0, 1);
    send_read(0, 2);
    send_read(1, 2);
    send_read(1, 3);
    send_read(2, 1);
  endtask

  task automatic test_clear();
    send_clear();
    send_read(0, 1);
  endtask

  task automatic random_items(input int count);
    int done;
    int pick;
    int hi;
    logic [GENO_BITS-1:0] geno;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        geno = ($urandom_range(0, 7) == 0) ? GENO_MISSING : GENO_BITS'($urandom_range(0, 2));
        send_code(geno);
        done++;
      end else if (pick < 95) begin
        if ($urandom_range(0, 3) != 0) begin
          hi = $urandom_range(1, eff_rows() - 1);
          send_read($urandom_range(0, hi - 1), hi);
        end else begin
          send_read($urandom_range(0, 31), $urandom_range(0, 31));
        end
        done++;
      end else if (pick < 97) begin
        send_clear();
        done++;
      end else begin
        send_item(REQ_NONE, GENO_BITS'($urandom_range(0, 3)),
                  ROW_BITS'($urandom_range(0, 31)), ROW_BITS'($urandom_range(0, 31)));
      end
    end
  endtask

  task automatic test_row_settings();
    logic [CFG_BITS-1:0] settings [8];
    settings = '{6'd32, 6'd5, 6'd2, 6'd63, 6'd0, 6'd17, 6'd1, 6'd33};
    foreach (settings[i]) begin
      set_rows(settings[i]);
      random_items(30);
      // sender waits for every outstanding result mid-phase
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (pending_counts.size() != 0) @(posedge clk);
      random_items(30);
    end
  endtask

  // back to back columns with no stalls on either side
  task automatic test_steady_stream();
    set_rows(6'd2);
    send_clear();
    steady = 1'b1;
    for (int c = 0; c < STEADY_COLUMNS; c++) begin
      send_code(GENO_BITS'($urandom_range(0, 2)));
      send_code(GENO_BITS'($urandom_range(0, 2)));
      if (c % 10 == 9) send_read(0, 1);
    end
    send_read(1, 0);
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    quiesce();
    test_empty_reads();
    test_joint_table();
    test_clear();
    test_row_settings();
    test_steady_stream();
    quiesce();
    if (pending_counts.size() != 0) begin
      errors++;
      $display("%0d results never arrived", pending_counts.size());
    end
    $display("sent %0d items over %0d row settings, %0d columns completed",
             items_sent, row_settings, columns_done);
    $display("checked %0d read results, including a stretch with no stalls", results_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout waiting on the block");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
